/* rtl/rfw_pkg.sv */
// Package for the fractional-N word calculator: field widths, division
// constants and the four-band parameter table.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rfw_pkg;

  // Field widths of the stream payload.
  localparam int FREQ_W  = 29;
  localparam int WORD_W  = 32;
  localparam int CTRL_W  = 16;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 2 * WORD_W + CTRL_W;

  // Internal widths.
  localparam int OFFS_W  = 24;  // rounded offset from the lower band edge
  localparam int STEPS_W = 19;  // count of 25 Hz steps, at most 400000
  localparam int QUOT_W  = 17;  // fraction / 53125, at most about 69700

  // Offset rounding and division by the step size (25 Hz).
  localparam logic [OFFS_W-1:0] STEP_HALF  = 24'd12;
  localparam int                STEP_SHIFT = 29;
  localparam logic [24:0]       STEP_RECIP = 25'd21474837;  // ceil(2^29 / 25)

  // Division of the remainder sum by 53125.
  localparam logic [15:0]       FRAC_DIV   = 16'd53125;
  localparam logic [WORD_W-1:0] FRAC_HALF  = 32'd26562;
  localparam int                FRAC_SHIFT = 47;
  localparam logic [31:0]       FRAC_RECIP = 32'd2649176251;  // floor(2^47 / 53125)

  // Band-select control values.
  localparam logic [CTRL_W-1:0] CTRL_70CM = 16'h0000;
  localparam logic [CTRL_W-1:0] CTRL_2M   = 16'h2002;
  localparam logic [CTRL_W-1:0] CTRL_6M   = 16'h8008;
  localparam logic [CTRL_W-1:0] CTRL_10M  = 16'hc00f;

  // Band indexes in the order they are searched.
  localparam logic [1:0] BAND_70CM = 2'd0;
  localparam logic [1:0] BAND_2M   = 2'd1;
  localparam logic [1:0] BAND_6M   = 2'd2;
  localparam logic [1:0] BAND_10M  = 2'd3;

  typedef struct packed {
    logic [FREQ_W-1:0] lo;
    logic [FREQ_W-1:0] hi;
    logic [WORD_W-1:0] base;
    logic [15:0]       rem0;
    logic              neg;
    logic [10:0]       quot;
    logic [14:0]       rstep;
    logic [22:0]       if_base;
    logic [15:0]       if_rem;
    logic [CTRL_W-1:0] ctrl;
  } band_t;

  // Per-band synthesizer parameters.
  function automatic band_t band_param(input logic [1:0] idx);
    band_t b;
    unique case (idx)
      BAND_70CM: b = '{29'd430000000, 29'd440000000, 32'd1357967601, 16'd3125,  1'b1,
                       11'd79,   15'd2571,  23'd432654,  16'd42170, CTRL_70CM};
      BAND_2M:   b = '{29'd144000000, 29'd146000000, 32'd1364283730, 16'd36250, 1'b1,
                       11'd237,  15'd7713,  23'd1297964, 16'd20260, CTRL_2M};
      BAND_6M:   b = '{29'd50000000,  29'd54000000,  32'd1421128885, 16'd15625, 1'b1,
                       11'd711,  15'd23139, 23'd3893893, 16'd7655,  CTRL_6M};
      default:   b = '{29'd28000000,  29'd29700000,  32'd1414812756, 16'd17500, 1'b0,
                       11'd1263, 15'd11989, 23'd6922476, 16'd37220, CTRL_10M};
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/radio_fracn_word_calc.sv */
// Seven-stage pipeline that turns a carrier frequency into the transmit and
// receive fractional-N words and the band-select value of its band.
// Accepts one transfer per clock unless a stalled output has backed up to the
// first stage, and returns one result transfer for each, in order. Every
// stage holds one item with its own valid bit and moves on when the stage
// after it is free, so a stall on the output only backs up as far as the
// first empty stage. Stages: band match, step count (multiply by the
// reciprocal of 25), word and remainder sums, IF adjust, two stages of
// division by 53125, and final add into the output register. Frequencies
// outside every band return status 1 with all words zero.
// Depends on rfw_pkg and rfw_div.
`default_nettype none

module radio_fracn_word_calc (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [rfw_pkg::S_DATA_W-1:0] s_tdata,  // [28:0] frequency_hz
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // [31:0] tx_frac_word, [63:32] rx_frac_word, [79:64] band_control
  output logic      [rfw_pkg::M_DATA_W-1:0] m_tdata,
  output logic      [0:0]                   m_tuser   // [0] status
);
  import rfw_pkg::*;

  localparam int NSTG = 7;

  logic [NSTG:1]   vld;
  logic [NSTG+1:1] rdy;

  // Per-stage handshake: a stage loads when it is empty or its successor loads.
  always_comb begin
    rdy[NSTG+1] = m_tready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = ~vld[k] | rdy[k+1];
    end
  end

  assign s_tready = rdy[1];
  assign m_tvalid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: band match and rounded offset from the lower edge.
  logic [FREQ_W-1:0] freq;
  logic [3:0]        in_band;
  logic [1:0]        band_sel;
  logic              hit_sel;
  band_t             bcand;
  band_t             bsel;
  logic [FREQ_W-1:0] offs_full;

  assign freq = s_tdata[FREQ_W-1:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bcand      = band_param(2'(i));
      in_band[i] = (freq >= bcand.lo) && (freq <= bcand.hi);
    end
    hit_sel = 1'b1;
    priority if (in_band[0]) band_sel = BAND_70CM;
    else if (in_band[1])     band_sel = BAND_2M;
    else if (in_band[2])     band_sel = BAND_6M;
    else if (in_band[3])     band_sel = BAND_10M;
    else begin
      band_sel = BAND_70CM;
      hit_sel  = 1'b0;
    end
    bsel      = band_param(band_sel);
    offs_full = freq - bsel.lo + FREQ_W'(STEP_HALF);
  end

  logic              s1_hit;
  logic [1:0]        s1_band;
  logic [OFFS_W-1:0] s1_offs;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_hit  <= hit_sel;
      s1_band <= band_sel;
      s1_offs <= offs_full[OFFS_W-1:0];
    end
  end

  // Stage 2: step count by multiplying with the reciprocal of 25.
  logic [48:0]        steps_prod;
  logic               s2_hit;
  logic [1:0]         s2_band;
  logic [STEPS_W-1:0] s2_steps;

  assign steps_prod = 49'(s1_offs) * 49'(STEP_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_hit   <= s1_hit;
      s2_band  <= s1_band;
      s2_steps <= steps_prod[STEP_SHIFT +: STEPS_W];
    end
  end

  // Stage 3: integer word and remainder sum with start and rounding terms.
  band_t             b3;
  logic [WORD_W-1:0] word_sum;
  logic [WORD_W-1:0] frac_sum;
  logic              s3_hit;
  logic [1:0]        s3_band;
  logic [WORD_W-1:0] s3_word;
  logic [WORD_W-1:0] s3_frac;

  assign b3       = band_param(s2_band);
  assign word_sum = b3.base + WORD_W'(b3.quot) * WORD_W'(s2_steps);
  assign frac_sum = WORD_W'(b3.rem0) + FRAC_HALF + WORD_W'(b3.rstep) * WORD_W'(s2_steps);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_hit  <= s2_hit;
      s3_band <= s2_band;
      s3_word <= word_sum;
      s3_frac <= frac_sum;
    end
  end

  // Stage 4: receive numerator and word lowered by the IF offset.
  band_t             b4;
  logic [WORD_W-1:0] rx_num;
  logic              s4_hit;
  logic [1:0]        s4_band;
  logic              s4_neg;
  logic [WORD_W-1:0] s4_word;
  logic [WORD_W-1:0] s4_word_rx;
  logic [WORD_W-1:0] s4_num_tx;
  logic [WORD_W-1:0] s4_num_rx;

  assign b4 = band_param(s3_band);

  always_comb begin
    if (b4.neg) begin
      rx_num = s3_frac + WORD_W'(b4.if_rem);
    end else if (s3_frac >= WORD_W'(b4.if_rem)) begin
      rx_num = s3_frac - WORD_W'(b4.if_rem);
    end else begin
      // A negative receive remainder clamps to zero.
      rx_num = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_hit     <= s3_hit;
      s4_band    <= s3_band;
      s4_neg     <= b4.neg;
      s4_word    <= s3_word;
      s4_word_rx <= s3_word - WORD_W'(b4.if_base);
      s4_num_tx  <= s3_frac;
      s4_num_rx  <= rx_num;
    end
  end

  // Stages 5 and 6: both remainder sums divided by 53125.
  logic [QUOT_W-1:0] q_tx;
  logic [QUOT_W-1:0] q_rx;

  rfw_div u_div_tx (
    .clk    (clk),
    .en_est (rdy[5]),
    .en_fix (rdy[6]),
    .num    (s4_num_tx),
    .quot   (q_tx)
  );

  rfw_div u_div_rx (
    .clk    (clk),
    .en_est (rdy[5]),
    .en_fix (rdy[6]),
    .num    (s4_num_rx),
    .quot   (q_rx)
  );

  logic              s5_hit;
  logic [1:0]        s5_band;
  logic              s5_neg;
  logic [WORD_W-1:0] s5_word;
  logic [WORD_W-1:0] s5_word_rx;
  logic              s6_hit;
  logic [1:0]        s6_band;
  logic              s6_neg;
  logic [WORD_W-1:0] s6_word;
  logic [WORD_W-1:0] s6_word_rx;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_hit     <= s4_hit;
      s5_band    <= s4_band;
      s5_neg     <= s4_neg;
      s5_word    <= s4_word;
      s5_word_rx <= s4_word_rx;
    end
    if (rdy[6]) begin
      s6_hit     <= s5_hit;
      s6_band    <= s5_band;
      s6_neg     <= s5_neg;
      s6_word    <= s5_word;
      s6_word_rx <= s5_word_rx;
    end
  end

  // Stage 7: apply the quotients with the band's sign into the output register.
  band_t             b7;
  logic [WORD_W-1:0] tx_fin;
  logic [WORD_W-1:0] rx_fin;
  logic [WORD_W-1:0] tx_out;
  logic [WORD_W-1:0] rx_out;
  logic [CTRL_W-1:0] ctrl_out;
  logic              status_out;

  assign b7     = band_param(s6_band);
  assign tx_fin = s6_neg ? s6_word - WORD_W'(q_tx) : s6_word + WORD_W'(q_tx);
  assign rx_fin = s6_neg ? s6_word_rx - WORD_W'(q_rx) : s6_word_rx + WORD_W'(q_rx);

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      status_out <= ~s6_hit;
      tx_out     <= s6_hit ? tx_fin : '0;
      rx_out     <= s6_hit ? rx_fin : '0;
      ctrl_out   <= s6_hit ? b7.ctrl : '0;
    end
  end

  assign m_tdata = {ctrl_out, rx_out, tx_out};
  assign m_tuser = status_out;

endmodule

`default_nettype wire

/* rtl/rfw_div.sv */
// Two-stage divider by the constant 53125 for a 32-bit numerator.
// Depends on rfw_pkg for the reciprocal and widths.
`default_nettype none

module rfw_div (
  input  wire logic                       clk,
  input  wire logic                       en_est,
  input  wire logic                       en_fix,
  input  wire logic [rfw_pkg::WORD_W-1:0] num,
  output logic      [rfw_pkg::QUOT_W-1:0] quot
);
  import rfw_pkg::*;

  logic [63:0]         prod_est;
  logic [QUOT_W-1:0]   q_est;
  logic [WORD_W-1:0]   num_d;
  logic [WORD_W:0]     back;
  logic [WORD_W:0]     rem;
  logic                bump;

  // Reciprocal estimate: the result is the true quotient or one below it.
  assign prod_est = 64'(num) * 64'(FRAC_RECIP);

  always_ff @(posedge clk) begin
    if (en_est) begin
      q_est <= prod_est[FRAC_SHIFT +: QUOT_W];
      num_d <= num;
    end
  end

  // Correction: step the estimate up when the remainder reaches the divisor.
  assign back = (WORD_W + 1)'(q_est) * (WORD_W + 1)'(FRAC_DIV);
  assign rem  = {1'b0, num_d} - back;
  assign bump = (rem >= (WORD_W + 1)'(FRAC_DIV));

  always_ff @(posedge clk) begin
    if (en_fix) begin
      quot <= q_est + QUOT_W'(bump);
    end
  end

endmodule

`default_nettype wire

/* rtl/rfw_checker.sv */
// Port-level checks for the fractional-N word calculator, bound to the top.
// Depends on rfw_pkg for the band-select values.
`default_nettype none

module rfw_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic [rfw_pkg::S_DATA_W-1:0] s_tdata,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [rfw_pkg::M_DATA_W-1:0] m_tdata,
  input wire logic [0:0]                   m_tuser
);
  import rfw_pkg::*;

  logic [CTRL_W-1:0] ctrl;
  assign ctrl = m_tdata[M_DATA_W-1 -: CTRL_W];

  // A result held back by the sink keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // An out-of-range result carries all-zero words.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("out-of-range result with nonzero data");

  // An in-range result carries one of the four band-select values.
  a_ctrl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |->
      (ctrl == CTRL_70CM || ctrl == CTRL_2M || ctrl == CTRL_6M || ctrl == CTRL_10M))
    else $error("unknown band-select value");

  // With nothing on the output the pipeline always takes input.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

  logic unused_in;
  assign unused_in = s_tvalid ^ (^s_tdata);

endmodule

bind radio_fracn_word_calc rfw_checker u_rfw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/sv/fracn_word_checker.sv */
// Checker for the fractional-N word calculator: watches both stream channels,
// predicts the status, transmit and receive words and band control for every
// accepted frequency, compares them in order. Depends on rfw_pkg for port widths.
module fracn_word_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [rfw_pkg::S_DATA_W-1:0] s_tdata,  // [28:0] frequency_hz
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  // [31:0] tx_frac_word, [63:32] rx_frac_word, [79:64] band_control
  input  logic [rfw_pkg::M_DATA_W-1:0] m_tdata,
  input  logic [0:0]                   m_tuser,  // [0] status
  output int                           mismatch_count,
  output int                           words_in_flight,
  output int                           results_compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic STATUS_IN_BAND      = 1'b0;
  localparam logic STATUS_OUT_OF_RANGE = 1'b1;
  localparam longint STEP_HZ  = 25;
  localparam longint FRAC_DEN = 53125;

  typedef struct packed {
    logic [28:0] freq;
    logic        status;
    logic [31:0] tx;
    logic [31:0] rx;
    logic [15:0] ctrl;
  } fracn_result_t;

  fracn_result_t expected_words[$];
  fracn_result_t oldest;

  // Synthesizer words for one carrier frequency; the first band that holds it wins.
  function automatic fracn_result_t predict_words(input logic [28:0] freq);
    longint fl, lo, hi, base, rem0, quot, rstep, if_base, if_rem;
    longint steps, word, frac, tx, rx, r;
    logic neg, found;
    logic [15:0] ctrl;
    fracn_result_t res;
    int b;
    res.freq   = freq;
    res.status = STATUS_OUT_OF_RANGE;
    res.tx     = '0;
    res.rx     = '0;
    res.ctrl   = '0;
    fl = freq;
    found = 1'b0;
    for (b = 0; b < 4; b++) begin
      case (b[1:0])
        rfw_pkg::BAND_70CM: begin
          lo = 430000000; hi = 440000000; base = 1357967601; rem0 = 3125; neg = 1'b1;
          quot = 79; rstep = 2571; if_base = 432654; if_rem = 42170; ctrl = 16'h0000;
        end
        rfw_pkg::BAND_2M: begin
          lo = 144000000; hi = 146000000; base = 1364283730; rem0 = 36250; neg = 1'b1;
          quot = 237; rstep = 7713; if_base = 1297964; if_rem = 20260; ctrl = 16'h2002;
        end
        rfw_pkg::BAND_6M: begin
          lo = 50000000; hi = 54000000; base = 1421128885; rem0 = 15625; neg = 1'b1;
          quot = 711; rstep = 23139; if_base = 3893893; if_rem = 7655; ctrl = 16'h8008;
        end
        default: begin
          lo = 28000000; hi = 29700000; base = 1414812756; rem0 = 17500; neg = 1'b0;
          quot = 1263; rstep = 11989; if_base = 6922476; if_rem = 37220; ctrl = 16'hc00f;
        end
      endcase
      if (!found && fl >= lo && fl <= hi) begin
        found = 1'b1;
        // Offset rounded to whole 25 Hz steps, remainder sum carries its rounding term.
        steps = (fl - lo + STEP_HZ / 2) / STEP_HZ;
        word  = base + quot * steps;
        frac  = rem0 + rstep * steps + FRAC_DEN / 2;
        if (neg) begin
          tx = word - frac / FRAC_DEN;
          rx = word - if_base - (frac + if_rem) / FRAC_DEN;
        end else begin
          r = frac - if_rem;
          if (r < 0) r = 0;
          tx = word + frac / FRAC_DEN;
          rx = word - if_base + r / FRAC_DEN;
        end
        res.status = STATUS_IN_BAND;
        res.tx     = tx[31:0];
        res.rx     = rx[31:0];
        res.ctrl   = ctrl;
      end
    end
    return res;
  endfunction

  task automatic report(input string what, input logic [28:0] freq,
                        input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] MISMATCH %s for %0d Hz: got %h, expected %h", $time, what, freq, got, want);
    mismatch_count++;
  endtask

  // Results are checked before the new frequency is queued; latency keeps them apart.
  always @(posedge clk) begin
    if (rst) begin
      mismatch_count   = 0;
      results_compared = 0;
      words_in_flight  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          report("result transfer with nothing outstanding", '0, m_tdata[31:0], '0);
        end else begin
          oldest = expected_words.pop_front();
          results_compared++;
          if (m_tuser[0] !== oldest.status)
            report("status", oldest.freq, 32'(m_tuser[0]), 32'(oldest.status));
          if (m_tdata[31:0] !== oldest.tx)
            report("tx_frac_word", oldest.freq, m_tdata[31:0], oldest.tx);
          if (m_tdata[63:32] !== oldest.rx)
            report("rx_frac_word", oldest.freq, m_tdata[63:32], oldest.rx);
          if (m_tdata[79:64] !== oldest.ctrl)
            report("band_control", oldest.freq, 32'(m_tdata[79:64]), 32'(oldest.ctrl));
        end
      end
      if (s_tvalid && s_tready)
        expected_words.push_back(predict_words(s_tdata[28:0]));
      words_in_flight = expected_words.size();
    end
  end

endmodule

/* tb/sv/tb_radio_fracn_word_calc.sv */
// Top of the fractional-N word calculator testbench: clock, reset, frequency
// stimulus and output back-pressure over several pacing phases, and the verdict.
// Depends on rfw_pkg, radio_fracn_word_calc and fracn_word_checker.
module tb_radio_fracn_word_calc;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 460;
  localparam int NUM_DIRECTED     = 24;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic [rfw_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic                         m_tready = 1'b0;
  logic                         s_tready;
  logic                         m_tvalid;
  logic [rfw_pkg::M_DATA_W-1:0] m_tdata;
  logic [0:0]                   m_tuser;

  int mismatch_count;
  int words_in_flight;
  int results_compared;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int items_sent     = 0;

  logic [28:0] directed_freqs [NUM_DIRECTED];

  radio_fracn_word_calc DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  fracn_word_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser),
    .mismatch_count   (mismatch_count),
    .words_in_flight  (words_in_flight),
    .results_compared (results_compared)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("[%0t] timeout with %0d results outstanding", $time, words_in_flight);
    $display("end of test: mismatches");
    $finish;
  end

  // Output side: random stalls plus a requested long hold-off, counted down here.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [28:0] band_edge(input int idx, input bit upper);
    case (idx[1:0])
      rfw_pkg::BAND_70CM: return upper ? 29'd440000000 : 29'd430000000;
      rfw_pkg::BAND_2M:   return upper ? 29'd146000000 : 29'd144000000;
      rfw_pkg::BAND_6M:   return upper ? 29'd54000000  : 29'd50000000;
      default:            return upper ? 29'd29700000  : 29'd28000000;
    endcase
  endfunction

  // Mostly in-band frequencies, with rounding boundaries, edges and full-range noise.
  function automatic logic [28:0] pick_freq();
    int kind, b;
    longint lo, span, f;
    kind = $urandom_range(99);
    b    = $urandom_range(3);
    lo   = band_edge(b, 1'b0);
    span = band_edge(b, 1'b1) - lo;
    if (kind < 62)
      f = lo + $urandom_range(span);
    else if (kind < 74)
      f = lo + 25 * longint'($urandom_range(span / 25 - 1)) + 12 + $urandom_range(1);
    else if (kind < 88)
      f = longint'(band_edge(b, kind[0])) + $urandom_range(40) - 20;
    else
      f = $urandom & 32'h1FFF_FFFF;
    return f[28:0];
  endfunction

  // One frequency transfer, preceded by random idle cycles.
  task automatic send_freq(input logic [28:0] freq);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= rfw_pkg::S_DATA_W'(freq);
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  initial begin : stimulus
    int phase, n;
    directed_freqs = '{
      29'd0, 29'h1FFF_FFFF,
      29'd430000000, 29'd440000000, 29'd429999999, 29'd440000001,
      29'd144000000, 29'd146000000, 29'd143999999, 29'd146000001,
      29'd50000000,  29'd54000000,  29'd49999999,  29'd54000001,
      29'd28000000,  29'd29700000,  29'd27999999,  29'd29700001,
      29'd430000012, 29'd430000013, 29'd28000037,  29'd28000038,
      29'd145123456, 29'd51999987
    };
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (phase == 0)
        for (n = 0; n < NUM_DIRECTED; n++) send_freq(directed_freqs[n]);
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Long output hold while input keeps coming, so the pipeline fills and backs up.
        if (phase == 0 && n == 200) hold_request = 80;
        send_freq(pick_freq());
      end
      // Sender goes quiet until every result of the phase is back.
      @(negedge clk);
      s_tvalid <= 1'b0;
      wait (words_in_flight == 0);
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d frequencies: all four bands with their edges, step rounding and",
             items_sent);
    $display("out-of-range values; %0d results compared under four pacing phases.",
             results_compared);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
rtl/rfw_pkg.sv
rtl/rfw_div.sv
rtl/radio_fracn_word_calc.sv
rtl/rfw_checker.sv
tb/sv/fracn_word_checker.sv
tb/sv/tb_radio_fracn_word_calc.sv
